// ===== rtl/modbus_rtu_request_framer_macros.svh =====
// Assertion macros used by the request framer top level.
// No dependencies; taken in by `include where assertions are written.
`ifndef MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define MBRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MBRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbrf_pkg.sv =====
// Types and constants of the Modbus RTU request framer.
// No dependencies; used by every module of the block by scoped names.
package mbrf_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int FRAME_OVERHEAD  = 9;

  localparam int COIL_QTY_LIMIT = (8 * (MAX_FRAME_BYTES - FRAME_OVERHEAD) < 1968) ?
                                  8 * (MAX_FRAME_BYTES - FRAME_OVERHEAD) : 1968;
  localparam int REG_QTY_LIMIT  = ((MAX_FRAME_BYTES - FRAME_OVERHEAD) / 2 < 123) ?
                                  (MAX_FRAME_BYTES - FRAME_OVERHEAD) / 2 : 123;

  localparam logic [10:0] READ_BITS_QTY_MAX   = 11'd2000;
  localparam logic [10:0] READ_REGS_QTY_MAX   = 11'd125;
  localparam logic [10:0] WRITE_COILS_QTY_MAX = 11'(COIL_QTY_LIMIT);
  localparam logic [10:0] WRITE_REGS_QTY_MAX  = 11'(REG_QTY_LIMIT);

  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h36;

  localparam logic [7:0] FN_CODE_READ_BITS   = 8'h02;
  localparam logic [7:0] FN_CODE_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FN_CODE_WRITE_REGS  = 8'h10;
  localparam logic [7:0] FN_CODE_READ_REGS   = 8'h04;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  localparam int CMDQ_DEPTH = 4;

  typedef enum logic [1:0] {
    FN_READ_BITS   = 2'd0,
    FN_WRITE_COILS = 2'd1,
    FN_WRITE_REGS  = 2'd2,
    FN_READ_REGS   = 2'd3
  } fn_sel_t;

  typedef enum logic [1:0] {
    CMD_ERROR  = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_DATA   = 2'd2
  } cmd_kind_t;

  // One unit of work for the byte serialiser. ndata counts the header or data
  // bytes; close appends the two CRC bytes.
  typedef struct packed {
    cmd_kind_t   kind;
    fn_sel_t     fsel;
    logic [15:0] addr;
    logic [10:0] qty;
    logic [15:0] data;
    logic [2:0]  ndata;
    logic        close;
  } cmd_t;

  typedef struct packed {
    logic vld;
    logic full;
  } cmdq_stat_t;

endpackage

// ===== rtl/mbrf_front.sv =====
// Front end of the request framer: accepts requests, checks them and
// tracks the open write frame. Depends on mbrf_pkg.
module mbrf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_opcode,
  input  logic [1:0]          in_function_sel,
  input  logic [15:0]         in_start_address,
  input  logic [10:0]         in_quantity,
  input  logic [15:0]         in_data_value,
  input  mbrf_pkg::cmdq_stat_t q_stat,
  output logic                cmd_push,
  output mbrf_pkg::cmd_t      cmd
);

  logic                frame_open_r, frame_open_nxt;
  mbrf_pkg::fn_sel_t   fn_r, fn_nxt;
  logic [10:0]         remain_r, remain_nxt;
  logic [7:0]          acc_r, acc_nxt;
  logic [2:0]          pos_r, pos_nxt;

  logic                accept;
  mbrf_pkg::fn_sel_t   fsel;
  logic                qty_ok;
  logic [10:0]         remain_dec;
  logic [7:0]          acc_or;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;
  assign fsel    = mbrf_pkg::fn_sel_t'(in_function_sel);

  always_comb begin
    unique case (fsel)
      mbrf_pkg::FN_READ_BITS:   qty_ok = in_quantity <= mbrf_pkg::READ_BITS_QTY_MAX;
      mbrf_pkg::FN_WRITE_COILS: qty_ok = in_quantity <= mbrf_pkg::WRITE_COILS_QTY_MAX;
      mbrf_pkg::FN_WRITE_REGS:  qty_ok = in_quantity <= mbrf_pkg::WRITE_REGS_QTY_MAX;
      default:                  qty_ok = in_quantity <= mbrf_pkg::READ_REGS_QTY_MAX;
    endcase
    if (in_quantity == 11'd0) begin
      qty_ok = 1'b0;
    end
  end

  assign remain_dec = remain_r - 11'd1;
  assign acc_or     = acc_r | (8'(in_data_value[0]) << pos_r);

  always_comb begin
    frame_open_nxt = frame_open_r;
    fn_nxt         = fn_r;
    remain_nxt     = remain_r;
    acc_nxt        = acc_r;
    pos_nxt        = pos_r;
    cmd_push       = 1'b0;
    cmd            = '0;
    cmd.kind       = mbrf_pkg::CMD_ERROR;
    cmd.fsel       = fsel;
    cmd.addr       = in_start_address;
    cmd.qty        = in_quantity;
    cmd.data       = in_data_value;

    if (accept) begin
      if (in_opcode == mbrf_pkg::OP_HEADER) begin
        cmd_push = 1'b1;
        if (!frame_open_r && qty_ok) begin
          cmd.kind = mbrf_pkg::CMD_HEADER;
          if (fsel == mbrf_pkg::FN_READ_BITS || fsel == mbrf_pkg::FN_READ_REGS) begin
            cmd.ndata = 3'd6;
            cmd.close = 1'b1;
          end else begin
            cmd.ndata      = 3'd7;
            frame_open_nxt = 1'b1;
            fn_nxt         = fsel;
            remain_nxt     = in_quantity;
            acc_nxt        = 8'd0;
            pos_nxt        = 3'd0;
          end
        end
      end else if (!frame_open_r || remain_r == 11'd0 ||
                   (fn_r != mbrf_pkg::FN_WRITE_COILS && fn_r != mbrf_pkg::FN_WRITE_REGS)) begin
        cmd_push = 1'b1;
      end else begin
        remain_nxt = remain_dec;
        cmd.kind   = mbrf_pkg::CMD_DATA;
        cmd.close  = (remain_dec == 11'd0);
        if (remain_dec == 11'd0) begin
          frame_open_nxt = 1'b0;
        end
        if (fn_r == mbrf_pkg::FN_WRITE_COILS) begin
          // Flush the packed byte once eight coils are in or the frame ends.
          if (pos_r == 3'd7 || remain_dec == 11'd0) begin
            cmd_push  = 1'b1;
            cmd.ndata = 3'd1;
            cmd.data  = {8'd0, acc_or};
            acc_nxt   = 8'd0;
            pos_nxt   = 3'd0;
          end else begin
            acc_nxt = acc_or;
            pos_nxt = pos_r + 3'd1;
          end
        end else begin
          cmd_push  = 1'b1;
          cmd.ndata = 3'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      fn_r         <= mbrf_pkg::FN_READ_BITS;
      remain_r     <= 11'd0;
      acc_r        <= 8'd0;
      pos_r        <= 3'd0;
    end else begin
      frame_open_r <= frame_open_nxt;
      fn_r         <= fn_nxt;
      remain_r     <= remain_nxt;
      acc_r        <= acc_nxt;
      pos_r        <= pos_nxt;
    end
  end

endmodule

// ===== rtl/mbrf_queue.sv =====
// Short command queue between front end and serialiser.
// Depends on mbrf_pkg for the command type and depth.
module mbrf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mbrf_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output mbrf_pkg::cmd_t       head_cmd,
  output mbrf_pkg::cmdq_stat_t stat
);

  localparam int PtrW = $clog2(mbrf_pkg::CMDQ_DEPTH);
  localparam int CntW = $clog2(mbrf_pkg::CMDQ_DEPTH + 1);

  mbrf_pkg::cmd_t  mem_r [mbrf_pkg::CMDQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign stat.vld  = (cnt_r != '0);
  assign stat.full = (cnt_r == CntW'(mbrf_pkg::CMDQ_DEPTH));
  assign do_push   = push && !stat.full;
  assign do_pop    = pop && stat.vld;
  assign head_cmd  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(mbrf_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(mbrf_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// ===== rtl/mbrf_back.sv =====
// Back end of the request framer: expands commands into frame bytes,
// runs the CRC and holds the result register. Depends on mbrf_pkg.
module mbrf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           slave_address,
  input  mbrf_pkg::cmd_t       cmd,
  input  mbrf_pkg::cmdq_stat_t q_stat,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_frame_byte,
  output logic                 out_last,
  output logic                 out_error
);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mbrf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [2:0]  step_r;
  logic [15:0] crc_r;
  logic        out_vld_r;
  logic [7:0]  byte_r;
  logic        last_r, error_r;

  logic        advance, last_step, is_data, is_crc_hi;
  logic [3:0]  total;
  logic [7:0]  fn_code, byte_cnt, hdr_byte, data_byte, emit_byte;
  logic [11:0] coil_round;
  logic [15:0] crc_base;

  assign out_empty      = !out_vld_r;
  assign out_frame_byte = byte_r;
  assign out_last       = last_r;
  assign out_error      = error_r;

  assign advance = q_stat.vld && (!out_vld_r || (out_pop && out_vld_r));

  always_comb begin
    if (cmd.kind == mbrf_pkg::CMD_ERROR) begin
      total = 4'd1;
    end else begin
      total = {1'b0, cmd.ndata} + (cmd.close ? 4'd2 : 4'd0);
    end
  end

  assign last_step = ({1'b0, step_r} == total - 4'd1);
  assign q_pop     = advance && last_step;
  assign is_data   = step_r < cmd.ndata;
  assign is_crc_hi = ({1'b0, step_r} == {1'b0, cmd.ndata} + 4'd1);

  always_comb begin
    unique case (cmd.fsel)
      mbrf_pkg::FN_READ_BITS:   fn_code = mbrf_pkg::FN_CODE_READ_BITS;
      mbrf_pkg::FN_WRITE_COILS: fn_code = mbrf_pkg::FN_CODE_WRITE_COILS;
      mbrf_pkg::FN_WRITE_REGS:  fn_code = mbrf_pkg::FN_CODE_WRITE_REGS;
      default:                  fn_code = mbrf_pkg::FN_CODE_READ_REGS;
    endcase
  end

  assign coil_round = {1'b0, cmd.qty} + 12'd7;
  assign byte_cnt   = (cmd.fsel == mbrf_pkg::FN_WRITE_COILS) ? coil_round[10:3]
                                                             : {cmd.qty[6:0], 1'b0};

  always_comb begin
    unique case (step_r)
      3'd0:    hdr_byte = slave_address;
      3'd1:    hdr_byte = fn_code;
      3'd2:    hdr_byte = cmd.addr[15:8];
      3'd3:    hdr_byte = cmd.addr[7:0];
      3'd4:    hdr_byte = {5'd0, cmd.qty[10:8]};
      3'd5:    hdr_byte = cmd.qty[7:0];
      default: hdr_byte = byte_cnt;
    endcase
  end

  // Registers go high byte first; a packed coil byte sits in the low half.
  assign data_byte = (step_r == 3'd0 && cmd.ndata == 3'd2) ? cmd.data[15:8] : cmd.data[7:0];

  assign crc_base = (cmd.kind == mbrf_pkg::CMD_HEADER && step_r == 3'd0) ?
                    mbrf_pkg::CRC_INIT : crc_r;

  always_comb begin
    if (cmd.kind == mbrf_pkg::CMD_ERROR) begin
      emit_byte = 8'd0;
    end else if (is_data) begin
      emit_byte = (cmd.kind == mbrf_pkg::CMD_HEADER) ? hdr_byte : data_byte;
    end else if (is_crc_hi) begin
      emit_byte = crc_r[15:8];
    end else begin
      emit_byte = crc_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= 3'd0;
      crc_r     <= mbrf_pkg::CRC_INIT;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        out_vld_r <= 1'b1;
        step_r    <= last_step ? 3'd0 : step_r + 3'd1;
        if (cmd.kind != mbrf_pkg::CMD_ERROR) begin
          if (is_data) begin
            crc_r <= crc_feed(crc_base, emit_byte);
          end else if (is_crc_hi) begin
            crc_r <= mbrf_pkg::CRC_INIT;
          end
        end
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r  <= emit_byte;
      error_r <= (cmd.kind == mbrf_pkg::CMD_ERROR);
      last_r  <= (cmd.kind != mbrf_pkg::CMD_ERROR) && !is_data && is_crc_hi;
    end
  end

endmodule

// ===== rtl/modbus_rtu_request_framer.sv =====
// Modbus RTU request framer, top level. The first byte of a request passes
// through the command queue and then the result register. The serialiser gives one
// frame byte per cycle while the result register is popped; a register data request
// gives two bytes, a coil request one or none, a header six or seven, closing two more.
// Reset (synchronous, active low) closes any open frame, empties the queue
// and the result register, and sets the slave address to 0x36.
`include "modbus_rtu_request_framer_macros.svh"

module modbus_rtu_request_framer (
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [1:0]  in_function_sel,
  input  logic [15:0] in_start_address,
  input  logic [10:0] in_quantity,
  input  logic [15:0] in_data_value,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_last,
  output logic        out_error,
  // slave address register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_slave_address
);

  logic [7:0]           slave_address_r;
  logic                 cmd_push, q_pop;
  mbrf_pkg::cmd_t       cmd_in, cmd_head;
  mbrf_pkg::cmdq_stat_t q_stat;
  logic                 out_pop;

  // The register is always writable; the user writes it only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= mbrf_pkg::SLAVE_ADDRESS_RESET;
    end else if (cfg_valid) begin
      slave_address_r <= cfg_slave_address;
    end
  end

  // Front end: check each request and hand one command at most to the queue.
  mbrf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (push),
    .in_full          (full),
    .in_opcode        (in_opcode),
    .in_function_sel  (in_function_sel),
    .in_start_address (in_start_address),
    .in_quantity      (in_quantity),
    .in_data_value    (in_data_value),
    .q_stat           (q_stat),
    .cmd_push         (cmd_push),
    .cmd              (cmd_in)
  );

  // Decouple checking from serialising; the front end stalls only while the queue is full.
  mbrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (q_pop),
    .head_cmd (cmd_head),
    .stat     (q_stat)
  );

  assign out_pop = pop && !empty;

  // Back end: one frame byte per cycle into the result register while it is free or popped.
  mbrf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .slave_address  (slave_address_r),
    .cmd            (cmd_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_empty      (empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last),
    .out_error      (out_error)
  );

  // An error result is a lone zero byte and never closes a frame.
  `MBRF_ASSERT_NOW(a_err_result, clk, rst_n, !empty && out_error, !out_last && out_frame_byte == 8'd0, "error result carries frame data")
  // A waiting command fills an empty result register at the next edge.
  `MBRF_ASSERT_NEXT(a_back_fills, clk, rst_n, q_stat.vld && empty, !empty, "serialiser stalled with free result register")
  // Requests are held back only by a queue that holds commands.
  `MBRF_ASSERT_NOW(a_full_has_cmds, clk, rst_n, full, q_stat.vld, "input stalled with empty queue")

endmodule
